// ----- sv/sha_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package sha_pkg;

  // Input word: one message byte plus framing flags
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       msg_end;
  } in_word_t;

  // Result word: one digest word with its index
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        digest_done;
  } out_word_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_RND,
    ST_ADD,
    ST_OUT
  } sha_state_t;

  localparam int unsigned ROUNDS     = 64;
  localparam int unsigned SCHED_LEN  = 16;
  localparam int unsigned HASH_WORDS = 8;

  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Big sigma 0, applied to a
  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // Big sigma 1, applied to e
  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Small sigma 0 for message expansion
  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // Small sigma 1 for message expansion
  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- sv/sha256_byte_stream_hasher.sv -----
// SHA-256 hasher that takes a message one byte per word and returns the digest.
//
// Input channel (in_valid/in_ready/in_data): one byte per word, with byte_valid
// to mark a real byte and msg_end to close the message. An end word with
// byte_valid low hashes whatever was taken so far, possibly nothing.
// Result channel (out_valid/out_ready/out_data): eight digest words, H0 first,
// digest_done set on the eighth.
// Flow: byte words are taken while idle. The word that completes a 64-byte
// block is followed by the compression rounds and the chaining add, with
// in_ready low, so no new word is taken until they finish.
// After an end word the block inserts padding and length bytes one per cycle
// through the same byte path (the length may spill into an extra block), runs
// one or two compressions, then presents the eight digest words.
// The single round unit (one round per cycle) sets the pace.
// A stalled receiver holds the current digest word; nothing else advances and
// no input is taken until the eighth word is accepted.
// Reset (rst_n low, synchronous) loads the initial hash values, clears the
// byte count and returns to idle; no clearing pass is needed.
module sha256_byte_stream_hasher (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sha_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sha_pkg::out_word_t out_data
);
  import sha_pkg::*;

  sha_state_t  st_r, st_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [31:0] win_r [SCHED_LEN];
  logic [31:0] win_nxt [SCHED_LEN];
  logic [31:0] v_r [HASH_WORDS];
  logic [31:0] v_nxt [HASH_WORDS];
  logic [31:0] chain_r [HASH_WORDS];
  logic [31:0] chain_nxt [HASH_WORDS];
  logic [5:0]  rnd_r, rnd_nxt;
  logic [63:0] len_r, len_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        len_ok_r, len_ok_nxt;
  logic        final_r, final_nxt;
  logic        pad_act_r, pad_act_nxt;
  logic [2:0]  oidx_r, oidx_nxt;

  logic        in_acc, out_acc;
  logic        ins_en, push_en;
  logic [7:0]  ins_byte, pad_byte;
  logic [31:0] push_word, w_new, t1, t2;
  logic        is_len;
  logic [63:0] cnt_sel;

  // Handshake outputs and result payload
  always_comb begin
    in_ready              = (st_r == ST_IDLE);
    out_valid             = (st_r == ST_OUT);
    out_data.digest_word  = chain_r[oidx_r];
    out_data.word_number  = oidx_r;
    out_data.digest_done  = (oidx_r == LAST_WORD);
  end

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.byte_valid && pos_r == LAST_POS) st_nxt = ST_RND;
          else if (in_data.msg_end) st_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pos_r == LAST_POS) st_nxt = ST_RND;
      end
      ST_RND: begin
        if (rnd_r == LAST_ROUND) st_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (final_r) st_nxt = ST_OUT;
        else if (pad_act_r) st_nxt = ST_PAD;
        else st_nxt = ST_IDLE;
      end
      ST_OUT: begin
        if (out_acc && oidx_r == LAST_WORD) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Padding byte: marker first, length bytes at the tail of the last block
  assign is_len   = !pad_first_r && len_ok_r && (pos_r >= LEN_POS);
  assign pad_byte = pad_first_r ? PAD_MARK : (is_len ? len_r[63:56] : 8'h00);

  // Shared byte path: message bytes when idle, padding bytes when padding
  assign ins_en   = (in_acc && in_data.byte_valid) || (st_r == ST_PAD);
  assign ins_byte = (st_r == ST_PAD) ? pad_byte : in_data.msg_byte;
  assign cnt_sel  = in_data.byte_valid ? (cnt_r + 64'd1) : cnt_r;

  // Round unit and message expansion
  assign w_new = win_r[0] + ssig0(win_r[1]) + win_r[9] + ssig1(win_r[14]);
  assign t1 = v_r[7] + bsig1(v_r[4]) + (v_r[6] ^ (v_r[4] & (v_r[5] ^ v_r[6])))
            + ROUND_K[rnd_r] + win_r[0];
  assign t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) | (v_r[2] & (v_r[0] | v_r[1])));

  assign push_en   = (ins_en && pos_r[1:0] == 2'b11) || (st_r == ST_RND);
  assign push_word = (st_r == ST_RND) ? w_new : {acc_r, ins_byte};

  // Datapath next values
  always_comb begin
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    rnd_nxt       = rnd_r;
    len_nxt       = len_r;
    pad_first_nxt = pad_first_r;
    len_ok_nxt    = len_ok_r;
    final_nxt     = final_r;
    pad_act_nxt   = pad_act_r;
    oidx_nxt      = oidx_r;
    v_nxt         = v_r;
    chain_nxt     = chain_r;
    win_nxt       = win_r;

    // Shift the schedule window
    if (push_en) begin
      for (int i = 0; i < SCHED_LEN - 1; i++) win_nxt[i] = win_r[i + 1];
      win_nxt[SCHED_LEN - 1] = push_word;
    end

    // Pack a byte; load the working variables when a block fills
    if (ins_en) begin
      acc_nxt = {acc_r[15:0], ins_byte};
      pos_nxt = pos_r + 6'd1;
      if (pos_r == LAST_POS) begin
        v_nxt   = chain_r;
        rnd_nxt = '0;
      end
    end

    // Count message bytes and start padding on the end word
    if (in_acc) begin
      if (in_data.byte_valid) cnt_nxt = cnt_sel;
      if (in_data.msg_end) begin
        pad_act_nxt   = 1'b1;
        pad_first_nxt = 1'b1;
        len_ok_nxt    = 1'b0;
        final_nxt     = 1'b0;
        len_nxt       = {cnt_sel[60:0], 3'b000};
      end
    end

    // Padding bookkeeping
    if (st_r == ST_PAD) begin
      pad_first_nxt = 1'b0;
      if (pad_first_r) len_ok_nxt = (pos_r < LEN_POS);
      if (is_len) begin
        len_nxt = {len_r[55:0], 8'h00};
        if (pos_r == LAST_POS) final_nxt = 1'b1;
      end else if (pos_r == LAST_POS) begin
        len_ok_nxt = 1'b1;
      end
    end

    // One compression round
    if (st_r == ST_RND) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
      rnd_nxt  = rnd_r + 6'd1;
    end

    // Fold the block into the chaining values
    if (st_r == ST_ADD) begin
      for (int i = 0; i < HASH_WORDS; i++) chain_nxt[i] = chain_r[i] + v_r[i];
      oidx_nxt = '0;
    end

    // Step through the digest; restart the chain after the last word
    if (out_acc) begin
      oidx_nxt = oidx_r + 3'd1;
      if (oidx_r == LAST_WORD) begin
        chain_nxt   = INIT_HASH;
        cnt_nxt     = '0;
        pad_act_nxt = 1'b0;
        final_nxt   = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      rnd_r       <= '0;
      pad_first_r <= 1'b0;
      len_ok_r    <= 1'b0;
      final_r     <= 1'b0;
      pad_act_r   <= 1'b0;
      oidx_r      <= '0;
      chain_r     <= INIT_HASH;
    end else begin
      st_r        <= st_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      pad_first_r <= pad_first_nxt;
      len_ok_r    <= len_ok_nxt;
      final_r     <= final_nxt;
      pad_act_r   <= pad_act_nxt;
      oidx_r      <= oidx_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    len_r <= len_nxt;
    v_r   <= v_nxt;
    win_r <= win_nxt;
  end

  // Input and result sides never open together
  assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input and output handshakes active together");

  // Chaining add follows exactly the last round
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RND && rnd_r == LAST_ROUND) |=> (st_r == ST_ADD))
    else $error("round sequence did not end in chaining add");

  // A block compression always starts at round zero with the byte position wrapped
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RND && $past(st_r) != ST_RND) |-> (rnd_r == '0 && pos_r == '0))
    else $error("compression started mid-block");

  // Padding only runs inside a message close
  assert property (@(posedge clk) disable iff (!rst_n) (st_r == ST_PAD) |-> pad_act_r)
    else $error("padding without a pending message end");

  // After the last digest word the block is idle and its counters cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && oidx_r == LAST_WORD) |=> (st_r == ST_IDLE && cnt_r == '0 && pos_r == '0))
    else $error("state not restored after digest");

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the SHA-256 byte stream hasher: digest predictor, scoreboard and top module.
package sha_tb_pkg;
  import sha_pkg::*;

  localparam int BLOCK_LEN = 64;
  localparam int LEN_SLOT  = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  class digest_scoreboard;
    logic [31:0] chain [8];
    logic [31:0] sched [16];
    logic [63:0] nbytes;
    out_word_t   digest_q [$];
    int unsigned err_count;

    function new();
      chain     = START_HASH;
      nbytes    = '0;
      err_count = 0;
      foreach (sched[i]) sched[i] = '0;
    endfunction

    function int pending();
      return digest_q.size();
    endfunction

    function logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Place one byte big-endian into the schedule
    function void load_byte(input int pos, input logic [7:0] b);
      int idx;
      int sh;
      idx = (pos >> 2) & 15;
      sh  = 24 - 8 * (pos & 3);
      sched[idx][sh +: 8] = b;
    endfunction

    // Run 64 rounds over the schedule and fold into the chaining values
    function void compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wr, t1, t2, x15, x2;
      w = sched;
      v = chain;
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          wr = w[r];
        end else begin
          x15 = w[(r - 15) & 15];
          x2  = w[(r - 2) & 15];
          wr  = w[r & 15] + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[(r - 7) & 15]
              + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
          w[r & 15] = wr;
        end
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + RND_CONST[r] + wr;
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    // Take one accepted input word; queue the digest when the message ends
    function void note_input(input in_word_t w);
      int p;
      logic [63:0] bitlen;
      out_word_t d;
      if (w.byte_valid) begin
        p = int'(nbytes[5:0]);
        load_byte(p, w.msg_byte);
        nbytes = nbytes + 1;
        if (p == BLOCK_LEN - 1) compress();
      end
      if (!w.msg_end) return;
      // pad: marker byte, zeros, then the bit length, spilling into an extra block if needed
      p = int'(nbytes[5:0]);
      load_byte(p, PAD_BYTE);
      p++;
      if (p > LEN_SLOT) begin
        while (p < BLOCK_LEN) begin
          load_byte(p, 8'h00);
          p++;
        end
        compress();
        p = 0;
      end
      while (p < LEN_SLOT) begin
        load_byte(p, 8'h00);
        p++;
      end
      bitlen    = nbytes << 3;
      sched[14] = bitlen[63:32];
      sched[15] = bitlen[31:0];
      compress();
      for (int j = 0; j < 8; j++) begin
        d.digest_word = chain[j];
        d.word_number = 3'(j);
        d.digest_done = (j == 7);
        digest_q.push_back(d);
      end
      chain  = START_HASH;
      nbytes = '0;
    endfunction

    task report(input string msg);
      err_count++;
      $display("MISMATCH: %s", msg);
    endtask

    // Compare one accepted digest word with the oldest expectation
    task check_result(input out_word_t got);
      out_word_t want;
      if (digest_q.size() == 0) begin
        report($sformatf("unexpected digest word %h idx %0d done %b",
                         got.digest_word, got.word_number, got.digest_done));
        return;
      end
      want = digest_q.pop_front();
      if (got.digest_word !== want.digest_word || got.word_number !== want.word_number ||
          got.digest_done !== want.digest_done)
        report($sformatf("digest got %h/%0d/%b want %h/%0d/%b",
                         got.digest_word, got.word_number, got.digest_done,
                         want.digest_word, want.word_number, want.digest_done));
    endtask
  endclass

endpackage

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;
  import sha_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS  = 100;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int send_idle_pct = 6;
  int recv_idle_pct = 59;
  int cycle_cnt     = 0;

  digest_scoreboard sb = new();

  sha256_byte_stream_hasher uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // Check each accepted digest word and stall the result side at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one word, idling first at random, and hold it until accepted
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(w);
  endtask

  // Hold off the sender until every queued digest word has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Send a message of len bytes, ending on the last byte or on an empty end word
  task automatic send_message(input int len, inout int n_items);
    in_word_t w;
    bit end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      // drop in a word without byte or end now and then
      if ($urandom_range(99) < 4) send_word(in_word_t'{8'($urandom_range(255)), 1'b0, 1'b0});
      w = in_word_t'{8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1)};
      send_word(w);
      n_items++;
    end
    if (!end_on_byte) begin
      send_word(in_word_t'{8'($urandom_range(255)), 1'b0, 1'b1});
      n_items++;
    end
  endtask

  // Mostly short messages, many around the padding boundaries, a few multi-block
  task automatic run_random(input int n);
    int cnt;
    int sel;
    int len;
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(99);
      if (sel < 55) len = $urandom_range(10);
      else if (sel < 90) len = $urandom_range(68, 52);
      else len = $urandom_range(130, 110);
      send_message(len, cnt);
    end
  endtask

  task automatic run_directed();
    // empty message
    send_word(in_word_t'{8'h00, 1'b0, 1'b1});
    // "abc", end flag on the last byte
    send_word(in_word_t'{8'h61, 1'b1, 1'b0});
    send_word(in_word_t'{8'h62, 1'b1, 1'b0});
    send_word(in_word_t'{8'h63, 1'b1, 1'b1});
    // ignored word, then two extreme bytes closed by an end word without a byte
    send_word(in_word_t'{8'hff, 1'b0, 1'b0});
    send_word(in_word_t'{8'hff, 1'b1, 1'b0});
    send_word(in_word_t'{8'h00, 1'b1, 1'b0});
    send_word(in_word_t'{8'ha5, 1'b0, 1'b1});
    // single-byte messages at both extremes
    send_word(in_word_t'{8'h00, 1'b1, 1'b1});
    send_word(in_word_t'{8'hff, 1'b1, 1'b1});
    // two empty messages back to back
    send_word(in_word_t'{8'hff, 1'b0, 1'b1});
    send_word(in_word_t'{8'h00, 1'b0, 1'b1});
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(PHASE_ITEMS);
    hold_until_drained();

    send_idle_pct = 59;
    recv_idle_pct = 6;
    run_random(PHASE_ITEMS);
    hold_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);

    // wait out the last digest, then watch for strays
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.err_count == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sha_pkg.sv
sv/sha256_byte_stream_hasher.sv
tb/sv/tb_top.sv
